// File: src/nwwm_pkg.sv
package nwwm_pkg;

  // Default sizes, handed down from the top level
  localparam int WORD_MAX_BYTES_DEF = 31;
  localparam int TEXT_KEEP_MAX_DEF  = 127;

  // Raw wake word storage is fixed by the register map
  localparam int RAW_WORD_BYTES = 31;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TOP_W      = 56;
  localparam int LEN_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LO   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MID  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_TOP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd4;

  // Byte codes
  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_E3    = 8'hE3;
  localparam logic [7:0] BYTE_80    = 8'h80;
  localparam logic [7:0] BYTE_81    = 8'h81;
  localparam logic [7:0] BYTE_82    = 8'h82;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_STOP  = 8'h2E;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_Z     = 8'h5A;
  localparam logic [7:0] CASE_SHIFT = 8'd32;

  // One classified request: up to three kept bytes, oldest in slot 0
  typedef struct packed {
    logic [2:0][7:0] data;
    logic [1:0]      cnt;
    logic            last;
  } emit_t;

  function automatic logic [7:0] lower_byte(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b inside {[CHAR_A:CHAR_Z]}) r = b + CASE_SHIFT;
    return r;
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return b inside {CHAR_SPACE, CHAR_COMMA, CHAR_STOP};
  endfunction

endpackage

// File: src/nwwm_text_if.sv
interface nwwm_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

// File: src/nwwm_result_if.sv
interface nwwm_result_if;
  logic valid;
  logic ready;
  logic word_found;
  logic message_done;

  modport source (output valid, output word_found, output message_done, input ready);
  modport sink   (input valid, input word_found, input message_done, output ready);
endinterface

// File: src/nwwm_word_build.sv
module nwwm_word_build #(
  parameter int WORD_MAX_BYTES = nwwm_pkg::WORD_MAX_BYTES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nwwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nwwm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [7:0]                     word_o [WORD_MAX_BYTES],
  output logic [WORD_MAX_BYTES-1:0]      mask_o,
  output logic                           empty_o,
  output logic                           ready_o
);
  import nwwm_pkg::*;

  logic [CFG_DATA_W-1:0] lo_q, mid_q, high_q;
  logic [TOP_W-1:0]      top_q;
  logic [LEN_W-1:0]      len_q;

  logic                  load_q, busy_q;
  logic [7:0]            scan_q [RAW_WORD_BYTES];
  logic [7:0]            word_q [WORD_MAX_BYTES];
  logic [WORD_MAX_BYTES-1:0] mask_q;
  logic [7:0]            raw_masked [RAW_WORD_BYTES];
  logic [RAW_WORD_BYTES*8-1:0] raw_all;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_q   <= '0;
      mid_q  <= '0;
      high_q <= '0;
      top_q  <= '0;
      len_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PATTERN_LO:   lo_q   <= cfg_data_i;
        CFG_PATTERN_MID:  mid_q  <= cfg_data_i;
        CFG_PATTERN_HIGH: high_q <= cfg_data_i;
        CFG_PATTERN_TOP:  top_q  <= cfg_data_i[TOP_W-1:0];
        CFG_PATTERN_LEN:  len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Raw bytes, zero past the programmed length
  assign raw_all = {top_q, high_q, mid_q, lo_q};

  always_comb begin
    for (int k = 0; k < RAW_WORD_BYTES; k++) begin
      raw_masked[k] = raw_all[8*k +: 8];
      if (LEN_W'(k) >= len_q) raw_masked[k] = BYTE_NUL;
    end
  end

  // Scan control: a write restarts the scan, one raw byte a step, or three for an ideographic comma
  logic [7:0] head;
  logic       triple, stop, append;

  always_comb begin
    head   = scan_q[0];
    triple = (scan_q[0] == BYTE_E3) && (scan_q[1] == BYTE_80) && (scan_q[2] == BYTE_81);
    stop   = (head == BYTE_NUL) || mask_q[0];
    append = busy_q && !stop && !triple && !is_punct(head);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= 1'b0;
      busy_q <= 1'b0;
      mask_q <= '0;
    end else if (cfg_we_i) begin
      load_q <= 1'b1;
      busy_q <= 1'b0;
    end else if (load_q) begin
      load_q <= 1'b0;
      busy_q <= 1'b1;
      mask_q <= '0;
    end else if (busy_q) begin
      if (stop) busy_q <= 1'b0;
      if (append) begin
        for (int j = 0; j < WORD_MAX_BYTES - 1; j++) mask_q[j] <= mask_q[j+1];
        mask_q[WORD_MAX_BYTES-1] <= 1'b1;
      end
    end
  end

  // Scan shift line and right-aligned normalized word
  always_ff @(posedge clk_i) begin
    if (load_q && !cfg_we_i) begin
      scan_q <= raw_masked;
    end else if (busy_q && !stop && !cfg_we_i) begin
      if (triple) begin
        for (int j = 0; j < RAW_WORD_BYTES; j++)
          scan_q[j] <= (j + 3 < RAW_WORD_BYTES) ? scan_q[(j+3) % RAW_WORD_BYTES] : BYTE_NUL;
      end else begin
        for (int j = 0; j < RAW_WORD_BYTES; j++)
          scan_q[j] <= (j + 1 < RAW_WORD_BYTES) ? scan_q[(j+1) % RAW_WORD_BYTES] : BYTE_NUL;
      end
    end
    if (append && !cfg_we_i) begin
      for (int j = 0; j < WORD_MAX_BYTES - 1; j++) word_q[j] <= word_q[j+1];
      word_q[WORD_MAX_BYTES-1] <= lower_byte(head);
    end
  end

  assign word_o  = word_q;
  assign mask_o  = mask_q;
  assign empty_o = ~|mask_q;
  assign ready_o = !load_q && !busy_q;

endmodule

// File: src/nwwm_front.sv
module nwwm_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  nwwm_text_if.sink       text_i,
  input  logic            space_i,
  output logic            push_o,
  output nwwm_pkg::emit_t entry_o
);
  import nwwm_pkg::*;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_E3   = 2'd1;
  localparam logic [1:0] PEND_E380 = 2'd2;

  logic [1:0] pend_q, pend_d;
  logic       dead_q, dead_d;

  assign text_i.ready = space_i;
  assign push_o       = text_i.valid && space_i;

  // Classify one byte into the bytes it keeps
  always_comb begin
    logic [7:0] b;
    logic [1:0] n;
    logic       go;
    b        = text_i.text_byte;
    n        = 2'd0;
    go       = 1'b1;
    entry_o  = '0;
    pend_d   = pend_q;
    dead_d   = dead_q;
    if (!dead_q) begin
      if (b == BYTE_NUL) begin
        // end of text: flush held prefix, ignore the rest
        if (pend_q != PEND_NONE) begin
          entry_o.data[n] = BYTE_E3;
          n = n + 2'd1;
        end
        if (pend_q == PEND_E380) begin
          entry_o.data[n] = BYTE_80;
          n = n + 2'd1;
        end
        pend_d = PEND_NONE;
        dead_d = 1'b1;
      end else begin
        case (pend_q)
          PEND_E3: begin
            if (b == BYTE_80) begin
              pend_d = PEND_E380;
              go     = 1'b0;
            end else begin
              entry_o.data[n] = BYTE_E3;
              n = n + 2'd1;
            end
          end
          PEND_E380: begin
            if (b inside {BYTE_81, BYTE_82}) begin
              pend_d = PEND_NONE;
              go     = 1'b0;
            end else begin
              entry_o.data[n] = BYTE_E3;
              n = n + 2'd1;
              entry_o.data[n] = BYTE_80;
              n = n + 2'd1;
            end
          end
          default: ;
        endcase
        if (go) begin
          if (b == BYTE_E3) begin
            pend_d = PEND_E3;
          end else begin
            pend_d = PEND_NONE;
            if (!is_punct(b)) begin
              entry_o.data[n] = lower_byte(b);
              n = n + 2'd1;
            end
          end
        end
      end
    end
    // message end: held prefix is kept
    if (text_i.last_byte) begin
      if (pend_d != PEND_NONE) begin
        entry_o.data[n] = BYTE_E3;
        n = n + 2'd1;
      end
      if (pend_d == PEND_E380) begin
        entry_o.data[n] = BYTE_80;
        n = n + 2'd1;
      end
      pend_d = PEND_NONE;
      dead_d = 1'b0;
    end
    entry_o.cnt  = n;
    entry_o.last = text_i.last_byte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PEND_NONE;
      dead_q <= 1'b0;
    end else if (push_o) begin
      pend_q <= pend_d;
      dead_q <= dead_d;
    end
  end

endmodule

// File: src/nwwm_queue.sv
module nwwm_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  nwwm_pkg::emit_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output nwwm_pkg::emit_t head_o
);
  import nwwm_pkg::*;

  emit_t      slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] fill_q;

  assign full_o  = fill_q[1];
  assign empty_o = (fill_q == 2'd0);
  assign head_o  = slot_q[rptr_q];

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= ~wptr_q;
      if (pop_i)  rptr_q <= ~rptr_q;
      if (push_i && !pop_i)      fill_q <= fill_q + 2'd1;
      else if (pop_i && !push_i) fill_q <= fill_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wptr_q] <= entry_i;
  end

endmodule

// File: src/nwwm_back.sv
module nwwm_back #(
  parameter int WORD_MAX_BYTES = nwwm_pkg::WORD_MAX_BYTES_DEF,
  parameter int TEXT_KEEP_MAX  = nwwm_pkg::TEXT_KEEP_MAX_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      head_valid_i,
  input  nwwm_pkg::emit_t           head_i,
  output logic                      pop_o,
  input  logic [7:0]                word_i [WORD_MAX_BYTES],
  input  logic [WORD_MAX_BYTES-1:0] mask_i,
  input  logic                      empty_i,
  nwwm_result_if.source             result_o
);
  import nwwm_pkg::*;

  localparam int KW = $clog2(TEXT_KEEP_MAX + 1);
  localparam logic [KW+1:0] KEEP_LIMIT = (KW+2)'(TEXT_KEEP_MAX);

  logic [7:0]    window_q [WORD_MAX_BYTES];
  logic [KW-1:0] kept_q;
  logic          found_q;
  logic          out_valid_q, out_found_q, out_done_q;

  logic [7:0]    win [4][WORD_MAX_BYTES];
  logic [3:1]    take, match;
  logic [1:0]    nt;
  logic          found_now;

  assign pop_o = head_valid_i && (!out_valid_q || result_o.ready);

  // Window after each of up to three kept bytes, and the match at each
  always_comb begin
    win[0] = window_q;
    for (int k = 1; k < 4; k++) begin
      for (int j = 0; j < WORD_MAX_BYTES - 1; j++) win[k][j] = win[k-1][j+1];
      win[k][WORD_MAX_BYTES-1] = head_i.data[k-1];
      match[k] = 1'b1;
      for (int j = 0; j < WORD_MAX_BYTES; j++)
        if (mask_i[j] && (win[k][j] != word_i[j])) match[k] = 1'b0;
      take[k] = (head_i.cnt >= 2'(k)) &&
                (({2'b00, kept_q} + (KW+2)'(k - 1)) < KEEP_LIMIT);
    end
    nt        = 2'(take[1]) + 2'(take[2]) + 2'(take[3]);
    found_now = found_q || empty_i || |(match & take);
  end

  // Message state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_q   <= '0;
      found_q  <= 1'b0;
      window_q <= '{default: '0};
    end else if (pop_o) begin
      if (head_i.last) begin
        kept_q   <= '0;
        found_q  <= 1'b0;
        window_q <= '{default: '0};
      end else begin
        kept_q   <= kept_q + KW'(nt);
        found_q  <= found_now;
        window_q <= win[nt];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_found_q <= found_now;
      out_done_q  <= head_i.last;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.word_found   = out_found_q;
  assign result_o.message_done = out_done_q;

endmodule

// File: src/normalized_wake_word_match_core.sv
// Wake word matcher: takes one text byte per request and returns one result per byte,
// word_found being sticky within the message and final where message_done is set.
// Text and word are normalized (space, comma and full stop dropped, ASCII capitals
// lower-cased, ideographic comma and full stop removed from the text, ideographic
// comma from the word). A classifier in front resolves the held E3 / E3 80 prefix
// and queues up to three kept bytes per request; the matcher behind shifts them
// into the recent-byte window and compares against the word combinationally, so
// the sustained rate is one byte per cycle while results are taken; a byte passes
// the queue slot and then the result register. After any configuration write the
// input is held off while the word normalizer scans the raw word.
module normalized_wake_word_match_core #(
  parameter int WORD_MAX_BYTES = nwwm_pkg::WORD_MAX_BYTES_DEF,
  parameter int TEXT_KEEP_MAX  = nwwm_pkg::TEXT_KEEP_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [nwwm_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nwwm_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nwwm_text_if.sink                      text_i,
  nwwm_result_if.source                  result_o
);
  import nwwm_pkg::*;

  logic [7:0]                word [WORD_MAX_BYTES];
  logic [WORD_MAX_BYTES-1:0] mask;
  logic                      word_empty, word_ready;
  logic                      push, pop, q_full, q_empty;
  emit_t                     entry, head;

  // Word registers and normalizer
  nwwm_word_build #(
    .WORD_MAX_BYTES(WORD_MAX_BYTES)
  ) u_word (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .word_o    (word),
    .mask_o    (mask),
    .empty_o   (word_empty),
    .ready_o   (word_ready)
  );

  // Byte classifier
  nwwm_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .text_i (text_i),
    .space_i(!q_full && word_ready),
    .push_o (push),
    .entry_o(entry)
  );

  // Decoupling queue
  nwwm_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .head_o (head)
  );

  // Window and match
  nwwm_back #(
    .WORD_MAX_BYTES(WORD_MAX_BYTES),
    .TEXT_KEEP_MAX (TEXT_KEEP_MAX)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(!q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .word_i      (word),
    .mask_i      (mask),
    .empty_i     (word_empty),
    .result_o    (result_o)
  );

endmodule
